/* hdl/dupfifo_pkg.sv */
// ----------------------------------------------------------------------------
// dupfifo_pkg: shared types and constants
// Operation and status codes, sequencer states and the control word that
// passes from the sequencer to the queue datapath.
// ----------------------------------------------------------------------------
package dupfifo_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int WORD_W    = 32;
	localparam int FUNC_W    = 2;
	localparam int STATUS_W  = 2;

	typedef enum logic [FUNC_W-1:0] {
		OP_PUSH  = 2'd0,
		OP_POP   = 2'd1,
		OP_QUERY = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_DONE  = 2'd0,
		STAT_DUP   = 2'd1,
		STAT_EMPTY = 2'd2,
		STAT_FULL  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE   = 2'd0,
		S_SCAN   = 2'd1,
		S_FINISH = 2'd2
	} state_t;

	typedef struct packed {
		logic finish;
		op_t  op;
		logic found;
	} ctrl_t;

endpackage

/* hdl/dupfifo_mem.sv */
// ----------------------------------------------------------------------------
// dupfifo_mem: entry storage
// One write port, one read port, registered read data. No reset.
// ----------------------------------------------------------------------------
module dupfifo_mem #(
	parameter int DEPTH = dupfifo_pkg::DEPTH_DEF,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                           clk,
	input  logic                           wr_en,
	input  logic [AW-1:0]                  wr_addr,
	input  logic [dupfifo_pkg::WORD_W-1:0] wr_data,
	input  logic                           rd_en,
	input  logic [AW-1:0]                  rd_addr,
	output logic [dupfifo_pkg::WORD_W-1:0] rd_data
);

	logic [dupfifo_pkg::WORD_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

/* hdl/dupfifo_ctrl.sv */
// ----------------------------------------------------------------------------
// dupfifo_ctrl: command sequencer and scan comparator
// Latches a command, walks the ring from head one entry per cycle through
// the single comparator and stops on the first match or after the last entry.
// ----------------------------------------------------------------------------
module dupfifo_ctrl #(
	parameter int DEPTH = dupfifo_pkg::DEPTH_DEF,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int CW = $clog2(DEPTH + 1)
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [dupfifo_pkg::FUNC_W-1:0]   func,
	input  logic [dupfifo_pkg::WORD_W-1:0]   value,
	input  logic [AW-1:0]                    head,
	input  logic [CW-1:0]                    count,
	input  logic [dupfifo_pkg::WORD_W-1:0]   rd_data,
	output logic                             busy,
	output logic                             rd_en,
	output logic [AW-1:0]                    rd_addr,
	output logic [dupfifo_pkg::WORD_W-1:0]   cmd_val,
	output dupfifo_pkg::ctrl_t               ctl
);

	dupfifo_pkg::state_t state_q, state_nxt;
	dupfifo_pkg::op_t    op_q, op_in;
	logic [dupfifo_pkg::WORD_W-1:0] val_q;
	logic [AW-1:0] ptr_q;
	logic [CW-1:0] left_q;
	logic          pend_q;
	logic          found_q;
	logic          accept;
	logic          match;
	logic          issue;

	assign op_in  = dupfifo_pkg::op_t'(func);
	assign accept = start && (state_q == dupfifo_pkg::S_IDLE);
	// compare sees the read data in the cycle after the read
	assign match  = pend_q && (rd_data == val_q);
	assign issue  = (state_q == dupfifo_pkg::S_SCAN) && (left_q != '0);

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			dupfifo_pkg::S_IDLE: begin
				if (start) begin
					if ((op_in == dupfifo_pkg::OP_PUSH || op_in == dupfifo_pkg::OP_QUERY)
						&& (count != '0)) begin
						state_nxt = dupfifo_pkg::S_SCAN;
					end else begin
						state_nxt = dupfifo_pkg::S_FINISH;
					end
				end
			end
			dupfifo_pkg::S_SCAN: begin
				if (match || (left_q == '0)) begin
					state_nxt = dupfifo_pkg::S_FINISH;
				end
			end
			dupfifo_pkg::S_FINISH: begin
				state_nxt = dupfifo_pkg::S_IDLE;
			end
			default: begin
				state_nxt = dupfifo_pkg::S_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		busy       = (state_q != dupfifo_pkg::S_IDLE);
		// a read of head goes out with every accepted command; pop uses it
		rd_en      = accept || issue;
		rd_addr    = (state_q == dupfifo_pkg::S_IDLE) ? head : ptr_q;
		cmd_val    = val_q;
		ctl.finish = (state_q == dupfifo_pkg::S_FINISH);
		ctl.op     = op_q;
		ctl.found  = found_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dupfifo_pkg::S_IDLE;
			op_q    <= dupfifo_pkg::OP_NONE;
			left_q  <= '0;
			pend_q  <= 1'b0;
			found_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (accept) begin
				op_q    <= op_in;
				left_q  <= count;
				pend_q  <= 1'b0;
				found_q <= 1'b0;
			end else if (state_q == dupfifo_pkg::S_SCAN) begin
				pend_q <= issue;
				if (issue) begin
					left_q <= left_q - 1'b1;
				end
				if (match) begin
					found_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			val_q <= value;
			ptr_q <= head;
		end else if (issue) begin
			ptr_q <= (ptr_q == AW'(DEPTH - 1)) ? '0 : ptr_q + 1'b1;
		end
	end

`ifndef NO_ASSERTIONS
	a_finish_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == dupfifo_pkg::S_FINISH) |=> (state_q == dupfifo_pkg::S_IDLE))
		else $error("finish state held longer than one cycle");

	a_scan_has_work: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == dupfifo_pkg::S_SCAN) && (left_q == '0) |-> pend_q || found_q)
		else $error("scan ran out of entries with no compare pending");
`endif

endmodule

/* hdl/duplicate_free_fifo_core.sv */
// ----------------------------------------------------------------------------
// duplicate_free_fifo_core: queue of distinct 32-bit words
// Ring buffer of DEPTH words. Push appends only words not already stored,
// pop removes the oldest word, query reports whether a word is stored.
// ----------------------------------------------------------------------------
//
//  channel   | handshake              | payload
//  ----------+------------------------+----------------------------------------
//  command   | start / busy           | func, value
//  result    | done (1-cycle strobe)  | status, found, popped_value, occupancy
//
//  Push and query scan the stored words one per cycle through one comparator
//  fed by the storage read port; a match ends the scan early, and a new
//  command is taken only once busy has fallen.
//  Pop, the unused code and push or query on an empty queue go through a read
//  of head, then the update.
//  done pulses the cycle after the update; busy is already low in that cycle.
//  Reset clears head, tail and count; storage holds garbage until written.
//  The receiver cannot stall: each result is shown for exactly one cycle.
//
module duplicate_free_fifo_core #(
	parameter int DEPTH = dupfifo_pkg::DEPTH_DEF,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int CW = $clog2(DEPTH + 1)
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	input  logic [dupfifo_pkg::FUNC_W-1:0]        func,
	input  logic signed [dupfifo_pkg::WORD_W-1:0] value,
	output logic                                  busy,
	output logic                                  done,
	output logic [dupfifo_pkg::STATUS_W-1:0]      status,
	output logic                                  found,
	output logic signed [dupfifo_pkg::WORD_W-1:0] popped_value,
	output logic [CW-1:0]                         occupancy
);

	dupfifo_pkg::ctrl_t ctl;

	// ring pointers and fill count
	logic [AW-1:0] head_q, tail_q, head_nxt, tail_nxt;
	logic [CW-1:0] count_q, count_nxt;

	// storage ports
	logic                           rd_en, wr_en;
	logic [AW-1:0]                  rd_addr;
	logic [dupfifo_pkg::WORD_W-1:0] rd_data, cmd_val;

	// result word, registered toward the port
	dupfifo_pkg::status_t           res_status;
	logic                           res_found;
	logic [dupfifo_pkg::WORD_W-1:0] res_popped;
	logic                           done_q;
	dupfifo_pkg::status_t           status_q;
	logic                           found_q;
	logic [dupfifo_pkg::WORD_W-1:0] popped_q;
	logic [CW-1:0]                  occ_q;

	dupfifo_ctrl #(
		.DEPTH(DEPTH)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.func    (func),
		.value   (value),
		.head    (head_q),
		.count   (count_q),
		.rd_data (rd_data),
		.busy    (busy),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.cmd_val (cmd_val),
		.ctl     (ctl)
	);

	dupfifo_mem #(
		.DEPTH(DEPTH)
	) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (tail_q),
		.wr_data (cmd_val),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Update in the finish cycle. The duplicate check wins over full, so a
	// stored word pushed into a full queue reports duplicate.
	always_comb begin
		res_status = dupfifo_pkg::STAT_DONE;
		res_found  = 1'b0;
		res_popped = '0;
		wr_en      = 1'b0;
		head_nxt   = head_q;
		tail_nxt   = tail_q;
		count_nxt  = count_q;
		if (ctl.finish) begin
			unique case (ctl.op)
				dupfifo_pkg::OP_PUSH: begin
					priority if (ctl.found) begin
						res_status = dupfifo_pkg::STAT_DUP;
						res_found  = 1'b1;
					end else if (count_q == CW'(DEPTH)) begin
						res_status = dupfifo_pkg::STAT_FULL;
					end else begin
						wr_en     = 1'b1;
						tail_nxt  = (tail_q == AW'(DEPTH - 1)) ? '0 : tail_q + 1'b1;
						count_nxt = count_q + 1'b1;
					end
				end
				dupfifo_pkg::OP_POP: begin
					if (count_q == '0) begin
						res_status = dupfifo_pkg::STAT_EMPTY;
					end else begin
						// head was read when the command was taken
						res_popped = rd_data;
						head_nxt   = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + 1'b1;
						count_nxt  = count_q - 1'b1;
					end
				end
				dupfifo_pkg::OP_QUERY: begin
					res_found = ctl.found;
				end
				dupfifo_pkg::OP_NONE: begin
					res_status = dupfifo_pkg::STAT_DONE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			head_q  <= head_nxt;
			tail_q  <= tail_nxt;
			count_q <= count_nxt;
			done_q  <= ctl.finish;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.finish) begin
			status_q <= res_status;
			found_q  <= res_found;
			popped_q <= res_popped;
			occ_q    <= count_nxt;
		end
	end

	assign done         = done_q;
	assign status       = status_q;
	assign found        = found_q;
	assign popped_value = popped_q;
	assign occupancy    = occ_q;

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("fill count above depth");

	a_empty_ring: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (tail_q == head_q))
		else $error("empty queue with tail apart from head");

	a_state_only_on_finish: assert property (@(posedge clk) disable iff (!arst_n)
		!ctl.finish |=> $stable(count_q) && $stable(head_q) && $stable(tail_q))
		else $error("queue state moved outside the finish cycle");

	a_done_follows_finish: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy && $past(ctl.finish))
		else $error("result strobe without a finished command");
`endif

endmodule

/* sim/tb_duplicate_free_fifo_core.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_duplicate_free_fifo_core: self-checking bench for the duplicate-free queue
// A shadow ring buffer predicts status, found, popped word and occupancy for
// every accepted command. Directed cases cover empty, full and duplicate
// handling, then random push/pop/query traffic runs under varying sender gaps.
// ----------------------------------------------------------------------------
module tb_duplicate_free_fifo_core;

	localparam int QDEPTH   = dupfifo_pkg::DEPTH_DEF;
	localparam int WORD_W   = dupfifo_pkg::WORD_W;
	localparam int FUNC_W   = dupfifo_pkg::FUNC_W;
	localparam int STATUS_W = dupfifo_pkg::STATUS_W;
	localparam int OCC_W    = $clog2(QDEPTH + 1);
	localparam int POOL_N   = 24;

	typedef dupfifo_pkg::op_t     op_t;
	typedef dupfifo_pkg::status_t status_t;

	typedef struct {
		status_t                   status;
		logic                      found;
		logic signed [WORD_W-1:0]  popped;
		logic [OCC_W-1:0]          occ;
	} reply_t;

	logic                         clk;
	logic                         arst_n;
	logic                         start;
	logic [FUNC_W-1:0]            func;
	logic signed [WORD_W-1:0]     value;
	logic                         busy;
	logic                         done;
	logic [STATUS_W-1:0]          status;
	logic                         found;
	logic signed [WORD_W-1:0]     popped_value;
	logic [OCC_W-1:0]             occupancy;

	// shadow copy of the queue
	logic signed [WORD_W-1:0]     shadow_ring [QDEPTH];
	int                           shadow_head;
	int                           shadow_count;

	reply_t                       reply_fifo [$];
	reply_t                       want;
	int                           errors;
	int                           sender_idle_pct;
	logic signed [WORD_W-1:0]     value_pool [POOL_N];

	duplicate_free_fifo_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.func         (func),
		.value        (value),
		.busy         (busy),
		.done         (done),
		.status       (status),
		.found        (found),
		.popped_value (popped_value),
		.occupancy    (occupancy)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	initial begin
		#2_000_000;
		$display("TB_ERROR");
		$finish;
	end

	function automatic bit shadow_holds(logic signed [WORD_W-1:0] v);
		for (int i = 0; i < shadow_count; i++)
			if (shadow_ring[(shadow_head + i) % QDEPTH] == v)
				return 1'b1;
		return 1'b0;
	endfunction

	// Applies one command to the shadow queue and queues the reply it causes.
	task automatic shadow_apply(op_t op, logic signed [WORD_W-1:0] v);
		reply_t r;
		r.status = dupfifo_pkg::STAT_DONE;
		r.found  = 1'b0;
		r.popped = '0;
		case (op)
			dupfifo_pkg::OP_PUSH: begin
				// duplicate check wins over the full check
				if (shadow_holds(v)) begin
					r.status = dupfifo_pkg::STAT_DUP;
					r.found  = 1'b1;
				end else if (shadow_count >= QDEPTH) begin
					r.status = dupfifo_pkg::STAT_FULL;
				end else begin
					shadow_ring[(shadow_head + shadow_count) % QDEPTH] = v;
					shadow_count++;
				end
			end
			dupfifo_pkg::OP_POP: begin
				if (shadow_count == 0) begin
					r.status = dupfifo_pkg::STAT_EMPTY;
				end else begin
					r.popped    = shadow_ring[shadow_head];
					shadow_head = (shadow_head + 1) % QDEPTH;
					shadow_count--;
				end
			end
			dupfifo_pkg::OP_QUERY: begin
				r.found = shadow_holds(v);
			end
			default: begin
			end
		endcase
		r.occ = OCC_W'(shadow_count);
		reply_fifo.push_back(r);
	endtask

	// Drives one word, holds it until accepted, then maybe leaves a gap.
	task automatic send_word(op_t op, logic signed [WORD_W-1:0] v);
		@(negedge clk);
		start = 1'b1;
		func  = op;
		value = v;
		do
			@(posedge clk);
		while (busy);
		shadow_apply(op, v);
		if ($urandom_range(99) < sender_idle_pct) begin
			@(negedge clk);
			start = 1'b0;
			repeat ($urandom_range(0, 17)) @(negedge clk);
		end
	endtask

	task automatic wait_drained();
		@(negedge clk);
		start = 1'b0;
		while (reply_fifo.size() != 0)
			@(negedge clk);
	endtask

	task automatic cmp_field(string name, logic [WORD_W-1:0] exp_v, logic [WORD_W-1:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
			errors++;
		end
	endtask

	// result checker: every strobe must match the oldest prediction
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (reply_fifo.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual status %0d",
					$time, status);
				errors++;
			end else begin
				want = reply_fifo.pop_front();
				cmp_field("status", WORD_W'(want.status), WORD_W'(status));
				cmp_field("found", WORD_W'(want.found), WORD_W'(found));
				cmp_field("popped_value", want.popped, popped_value);
				cmp_field("occupancy", WORD_W'(want.occ), WORD_W'(occupancy));
			end
		end
	end

	task automatic test_empty_queue();
		send_word(dupfifo_pkg::OP_POP, 32'sh1234_5678);
		send_word(dupfifo_pkg::OP_QUERY, 32'sh8000_0000);
		send_word(dupfifo_pkg::OP_NONE, 32'shFFFF_FFFF);
	endtask

	task automatic test_fill_to_full();
		send_word(dupfifo_pkg::OP_PUSH, 32'sh8000_0000);
		send_word(dupfifo_pkg::OP_PUSH, 32'sh7FFF_FFFF);
		send_word(dupfifo_pkg::OP_PUSH, 32'sh0000_0000);
		send_word(dupfifo_pkg::OP_PUSH, 32'shFFFF_FFFF);
		send_word(dupfifo_pkg::OP_PUSH, 32'sh5555_5555);
		send_word(dupfifo_pkg::OP_PUSH, 32'shAAAA_AAAA);
		for (int i = 1; i <= 10; i++)
			send_word(dupfifo_pkg::OP_PUSH,
				WORD_W'(i) * 32'sh0F0F_1234 + 32'sh0000_0101);
		// full queue: new word refused, stored word reported as duplicate
		send_word(dupfifo_pkg::OP_PUSH, 32'sh0123_4567);
		send_word(dupfifo_pkg::OP_PUSH, 32'sh8000_0000);
		send_word(dupfifo_pkg::OP_QUERY, 32'sh7FFF_FFFF);
	endtask

	task automatic test_pop_order();
		send_word(dupfifo_pkg::OP_POP, 32'sh0);
		send_word(dupfifo_pkg::OP_POP, 32'shFFFF_FFFF);
		wait_drained();
	endtask

	// Bursts lean toward filling or draining so both full and empty recur;
	// most words come from a small pool so duplicates and hits are common.
	task automatic test_random_traffic(int n_items, int idle_pct);
		bit                       filling;
		int                       r;
		op_t                      op;
		logic signed [WORD_W-1:0] v;
		sender_idle_pct = idle_pct;
		filling = 1'b1;
		for (int k = 0; k < n_items; k++) begin
			if (k % 30 == 0)
				filling = $urandom_range(1);
			r = $urandom_range(99);
			if (filling)
				op = (r < 65) ? dupfifo_pkg::OP_PUSH :
					(r < 75) ? dupfifo_pkg::OP_POP :
					(r < 95) ? dupfifo_pkg::OP_QUERY : dupfifo_pkg::OP_NONE;
			else
				op = (r < 20) ? dupfifo_pkg::OP_PUSH :
					(r < 80) ? dupfifo_pkg::OP_POP :
					(r < 95) ? dupfifo_pkg::OP_QUERY : dupfifo_pkg::OP_NONE;
			if ($urandom_range(99) < 70)
				v = value_pool[$urandom_range(POOL_N - 1)];
			else
				v = $urandom;
			send_word(op, v);
		end
		wait_drained();
	endtask

	initial begin
		errors          = 0;
		sender_idle_pct = 35;
		shadow_head     = 0;
		shadow_count    = 0;
		arst_n          = 1'b0;
		start           = 1'b0;
		func            = dupfifo_pkg::OP_NONE;
		value           = '0;
		value_pool[0]   = 32'sh8000_0000;
		value_pool[1]   = 32'sh7FFF_FFFF;
		value_pool[2]   = 32'sh0000_0000;
		value_pool[3]   = 32'shFFFF_FFFF;
		for (int i = 4; i < POOL_N; i++)
			value_pool[i] = $urandom;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_empty_queue();
		test_fill_to_full();
		test_pop_order();
		test_random_traffic(200, 35);
		test_random_traffic(200, 71);
		test_random_traffic(200, 0);

		wait_drained();
		repeat (3 * QDEPTH) @(posedge clk);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
